// ----- rtl/rdcc_pkg.sv -----
// ============================================================================
// rdcc_pkg
// Shared types and constants for the ramped drive command controller.
// ============================================================================
`default_nettype none

package rdcc_pkg;

  // Width of a duty value and of every speed that is compared against it.
  localparam int unsigned DUTY_W   = 8;
  localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

  localparam int unsigned CMD_W    = 8;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [DUTY_W-1:0] TICK_INC_RST   = DUTY_W'(5);
  localparam logic [DUTY_W-1:0] SPEED_STEP_RST = DUTY_W'(5);
  localparam logic [DUTY_W-1:0] SPEED_RST      = DUTY_W'(30);

  // Register indexes, taken from paddr[2].
  localparam logic REG_TICK_INC   = 1'b0;
  localparam logic REG_SPEED_STEP = 1'b1;

  // Item kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // Drive command codes.
  localparam logic [CMD_W-1:0] CMD_FWD        = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_BACK       = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_STOP       = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_SPOT_LEFT  = CMD_W'(4);
  localparam logic [CMD_W-1:0] CMD_SPOT_RIGHT = CMD_W'(5);
  localparam logic [CMD_W-1:0] CMD_STOP_TURN  = CMD_W'(6);
  localparam logic [CMD_W-1:0] CMD_FASTER     = CMD_W'(7);
  localparam logic [CMD_W-1:0] CMD_SLOWER     = CMD_W'(8);

  typedef enum logic [1:0] {
    MOT_STOP = 2'd0,
    MOT_FWD  = 2'd1,
    MOT_BACK = 2'd2
  } motion_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_RAMP       = 4'b0010,
    PH_DRAIN_REV  = 4'b0100,
    PH_DRAIN_STOP = 4'b1000
  } phase_t;

endpackage : rdcc_pkg

`default_nettype wire

// ----- rtl/ramped_drive_command_controller.sv -----
// ============================================================================
// ramped_drive_command_controller
// Soft-start drive controller: ramp ticks move the duty toward its target,
// drive commands set direction, target and speed.
// ============================================================================
//
//  Channel  Direction  Handshake          Beat contents
//  in_      input      in_valid/in_stall  kind, command
//  out_     output     out_valid/out_stall duty, directions, motion, speed,
//                                          busy, unknown flag
//  cfg      input      APB (psel..pready) ramp increment at 0x0, speed_step at 0x4
//
//  An accepted input beat passes through the input register, then through the
//  step logic into the result register.
//  One beat is accepted every cycle while the result is not stalled; the state
//  update loop closes within the single step stage.
//  rst_n is synchronous; it empties both stages and restores the reset state.
//  A stalled result holds both stages; in_stall rises only while the input
//  register is full and cannot move on.
// ============================================================================
`default_nettype none

module ramped_drive_command_controller
  import rdcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_kind,
  input  wire logic [CMD_W-1:0]  in_command,

  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DUTY_W-1:0]      out_duty,
  output logic                   out_left_forward,
  output logic                   out_right_forward,
  output logic [1:0]             out_motion,
  output logic [DUTY_W-1:0]      out_set_speed,
  output logic                   out_ramp_busy,
  output logic                   out_unknown_command,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  // Configuration registers.
  logic [DUTY_W-1:0] tick_inc_r;
  logic [DUTY_W-1:0] speed_step_r;

  // Input stage.
  logic             s1_valid_r;
  logic             s1_kind_r;
  logic [CMD_W-1:0] s1_cmd_r;

  // Controller state.
  logic [DUTY_W-1:0] ramp_speed_r,  ramp_speed_nxt;
  logic [DUTY_W-1:0] ramp_target_r, ramp_target_nxt;
  logic [DUTY_W-1:0] duty_r,        duty_nxt;
  motion_t           motion_r,      motion_nxt;
  phase_t            phase_r,       phase_nxt;
  motion_t           pending_r,     pending_nxt;
  logic [DUTY_W-1:0] speed_r,       speed_nxt;
  logic              left_lvl_r,    left_lvl_nxt;
  logic              right_lvl_r,   right_lvl_nxt;
  logic              unknown_nxt;

  // Result register.
  logic              out_valid_r;
  logic [DUTY_W-1:0] out_duty_r;
  logic              out_left_r;
  logic              out_right_r;
  motion_t           out_motion_r;
  logic [DUTY_W-1:0] out_speed_r;
  logic              out_busy_r;
  logic              out_unknown_r;

  logic advance;
  logic step_en;
  logic cfg_wr;

  assign advance  = !out_valid_r || !out_stall;
  assign step_en  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_inc_r   <= TICK_INC_RST;
      speed_step_r <= SPEED_STEP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TICK_INC:   tick_inc_r   <= pwdata[DUTY_W-1:0];
        REG_SPEED_STEP: speed_step_r <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_TICK_INC:   prdata = CFG_DW'(tick_inc_r);
      REG_SPEED_STEP: prdata = CFG_DW'(speed_step_r);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind_r <= in_kind;
      s1_cmd_r  <= in_command;
    end
  end

  // --------------------------------------------------------------------------
  // Step logic
  // --------------------------------------------------------------------------
  always_comb begin
    logic [DUTY_W:0]   sum;
    logic [DUTY_W-1:0] gap;
    logic              do_begin;
    motion_t           begin_dir;
    motion_t           opposite;

    ramp_speed_nxt  = ramp_speed_r;
    ramp_target_nxt = ramp_target_r;
    duty_nxt        = duty_r;
    motion_nxt      = motion_r;
    phase_nxt       = phase_r;
    pending_nxt     = pending_r;
    speed_nxt       = speed_r;
    left_lvl_nxt    = left_lvl_r;
    right_lvl_nxt   = right_lvl_r;
    unknown_nxt     = 1'b0;
    do_begin        = 1'b0;
    begin_dir       = MOT_FWD;
    opposite        = MOT_BACK;
    sum             = '0;
    gap             = '0;

    if (s1_kind_r == KIND_TICK) begin
      if (phase_r != PH_IDLE) begin
        if (ramp_speed_r < ramp_target_r) begin
          sum = {1'b0, ramp_speed_r} + {1'b0, tick_inc_r};
          ramp_speed_nxt = (sum > {1'b0, ramp_target_r}) ? ramp_target_r
                                                          : sum[DUTY_W-1:0];
          duty_nxt = ramp_speed_nxt;
        end else if (ramp_speed_r > ramp_target_r) begin
          gap = ramp_speed_r - ramp_target_r;
          ramp_speed_nxt = (gap < tick_inc_r) ? ramp_target_r
                                              : ramp_speed_r - tick_inc_r;
          duty_nxt = ramp_speed_nxt;
        end

        if (ramp_speed_nxt == ramp_target_r) begin
          unique case (phase_r)
            PH_DRAIN_STOP: begin
              motion_nxt = MOT_STOP;
              duty_nxt   = '0;
              phase_nxt  = PH_IDLE;
            end
            PH_DRAIN_REV: begin
              // Drained to zero: flip direction, the ramp up starts next tick.
              duty_nxt  = '0;
              do_begin  = 1'b1;
              begin_dir = (pending_r == MOT_BACK) ? MOT_BACK : MOT_FWD;
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
      end
    end else begin
      // Every command abandons a ramp where it stands.
      phase_nxt   = PH_IDLE;
      pending_nxt = MOT_STOP;
      unique case (s1_cmd_r)
        CMD_FWD, CMD_BACK: begin
          begin_dir = (s1_cmd_r == CMD_FWD) ? MOT_FWD : MOT_BACK;
          opposite  = (s1_cmd_r == CMD_FWD) ? MOT_BACK : MOT_FWD;
          if (motion_r == opposite && ramp_speed_r != '0) begin
            ramp_target_nxt = '0;
            pending_nxt     = begin_dir;
            phase_nxt       = PH_DRAIN_REV;
          end else begin
            do_begin = 1'b1;
          end
        end
        CMD_STOP: begin
          ramp_target_nxt = '0;
          if (ramp_speed_r == '0) begin
            motion_nxt = MOT_STOP;
            duty_nxt   = '0;
          end else begin
            phase_nxt = PH_DRAIN_STOP;
          end
        end
        CMD_SPOT_LEFT: begin
          left_lvl_nxt  = 1'b0;
          right_lvl_nxt = 1'b1;
          duty_nxt      = speed_r;
        end
        CMD_SPOT_RIGHT: begin
          left_lvl_nxt  = 1'b1;
          right_lvl_nxt = 1'b0;
          duty_nxt      = speed_r;
        end
        CMD_STOP_TURN: duty_nxt = '0;
        CMD_FASTER: begin
          sum       = {1'b0, speed_r} + {1'b0, speed_step_r};
          speed_nxt = sum[DUTY_W] ? DUTY_MAX : sum[DUTY_W-1:0];
        end
        CMD_SLOWER: begin
          speed_nxt = (speed_r < speed_step_r) ? '0 : speed_r - speed_step_r;
        end
        default: unknown_nxt = 1'b1;
      endcase
    end

    if (do_begin) begin
      left_lvl_nxt    = (begin_dir == MOT_FWD);
      right_lvl_nxt   = (begin_dir == MOT_FWD);
      motion_nxt      = begin_dir;
      pending_nxt     = MOT_STOP;
      ramp_target_nxt = speed_r;
      phase_nxt       = (ramp_speed_nxt != speed_r) ? PH_RAMP : PH_IDLE;
    end
  end

  // --------------------------------------------------------------------------
  // State and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_speed_r  <= '0;
      ramp_target_r <= '0;
      duty_r        <= '0;
      motion_r      <= MOT_STOP;
      phase_r       <= PH_IDLE;
      pending_r     <= MOT_STOP;
      speed_r       <= SPEED_RST;
      left_lvl_r    <= 1'b0;
      right_lvl_r   <= 1'b0;
    end else if (step_en) begin
      ramp_speed_r  <= ramp_speed_nxt;
      ramp_target_r <= ramp_target_nxt;
      duty_r        <= duty_nxt;
      motion_r      <= motion_nxt;
      phase_r       <= phase_nxt;
      pending_r     <= pending_nxt;
      speed_r       <= speed_nxt;
      left_lvl_r    <= left_lvl_nxt;
      right_lvl_r   <= right_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_duty_r    <= duty_nxt;
      out_left_r    <= left_lvl_nxt;
      out_right_r   <= right_lvl_nxt;
      out_motion_r  <= motion_nxt;
      out_speed_r   <= speed_nxt;
      out_busy_r    <= (phase_nxt != PH_IDLE);
      out_unknown_r <= unknown_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_duty            = out_duty_r;
  assign out_left_forward    = out_left_r;
  assign out_right_forward   = out_right_r;
  assign out_motion          = out_motion_r;
  assign out_set_speed       = out_speed_r;
  assign out_ramp_busy       = out_busy_r;
  assign out_unknown_command = out_unknown_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled while the input register is empty");

  a_pending_only_in_reversal: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != MOT_STOP |-> phase_r == PH_DRAIN_REV)
    else $error("pending direction held outside a reversal drain");

  a_drain_targets_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DRAIN_REV || phase_r == PH_DRAIN_STOP) |-> ramp_target_r == '0)
    else $error("drain phase with a nonzero target");

  a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_busy_r == (phase_r != PH_IDLE))
    else $error("result busy flag disagrees with the ramp phase");

endmodule : ramped_drive_command_controller

`default_nettype wire
